// ----- hdl/m2s_pkg.sv -----
// ----------------------------------------------------------------------------
// m2s_pkg
// Shared widths, register codes and sideband type of the 2x2 matrix
// eigenvalue signature pipeline.
// ----------------------------------------------------------------------------
package m2s_pkg;

    localparam int DATA_W      = 32;              // matrix entry, Q16.16
    localparam int TRACE_W     = DATA_W + 1;      // a11 + a22, a11 - a22
    localparam int ABS_W       = DATA_W + 1;      // |a11 - a22|
    localparam int PROD_W      = 2 * DATA_W;      // a12 * a21
    localparam int SQ_W        = 2 * ABS_W;       // |a11 - a22|^2
    localparam int SUM_W       = SQ_W + 2;        // signed discriminant
    localparam int DISC_W      = SQ_W;            // clamped discriminant
    localparam int RAD_W       = 68;              // radicand, even width
    localparam int ROOT_W      = RAD_W / 2;       // floor square root
    localparam int REM_W       = ROOT_W + 2;      // partial remainder
    localparam int STEP_W      = REM_W + 2;       // remainder with next pair
    localparam int SQRT_STAGES = RAD_W / 2;       // one root bit a stage
    localparam int EIG_W       = ROOT_W + 2;      // twice an eigenvalue
    localparam int TOL_W       = 31;
    localparam int SIG_W       = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = TOL_W;
    localparam int IN_TDATA_W  = 4 * DATA_W;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOLERANCE  = 1'b0,
        CFG_COUNT_MODE = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic                      last;
        logic signed [TRACE_W-1:0] trace;
    } side_t;

endpackage

// ----- hdl/matrix2x2_signature.sv -----
// ----------------------------------------------------------------------------
// matrix2x2_signature
// Eigenvalue signature (or count at or above tolerance) of one real 2x2 Q16.16
// matrix per item, through a fully pipelined exact square root.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_axis    in         s_axis_tvalid/tready   a11..a22 in tdata, last in tlast
//  m_axis    out        m_axis_tvalid/tready   signature in tdata, last in tlast
//  cfg       in         cfg_we                 cfg_index, cfg_data
//
//  One item per cycle while the skid register is empty; three arithmetic
//  stages, 34 square root stages (one root bit each) and the output register.
//  Reset clears all valid bits; the tolerance and mode registers reset to 0.
//  A stalled output parks one item in a skid register; s_axis_tready drops
//  only while that register is full, and the whole pipeline holds then.
// ----------------------------------------------------------------------------
module matrix2x2_signature
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // a11 [31:0], a21 [63:32], a12 [95:64], a22 [127:96]
    input  logic [m2s_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // signature [2:0], zero [7:3]
    output logic [m2s_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                cfg_we,
    input  logic [m2s_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [m2s_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import m2s_pkg::*;

    logic [TOL_W-1:0] tol_reg;
    logic             count_mode_reg;

    logic en;

    logic signed [DATA_W-1:0]  a11, a21, a12, a22;
    logic signed [TRACE_W-1:0] trace_in, diff_in;
    logic [ABS_W-1:0]          abs_in;
    logic signed [PROD_W-1:0]  prod_in;

    logic                      a_valid_reg;
    side_t                     a_side_reg;
    logic [ABS_W-1:0]          a_abs_reg;
    logic signed [PROD_W-1:0]  a_prod_reg;

    logic                      b_valid_reg;
    side_t                     b_side_reg;
    logic [SQ_W-1:0]           b_sq_reg;
    logic signed [PROD_W-1:0]  b_prod_reg;

    logic signed [SUM_W-1:0]   disc_sum;
    logic [DISC_W-1:0]         disc_next;
    logic                      c_valid_reg;
    side_t                     c_side_reg;
    logic [DISC_W-1:0]         c_disc_reg;

    logic                      sq_valid;
    logic [ROOT_W-1:0]         sq_root;
    side_t                     sq_side;

    logic signed [EIG_W-1:0]   e_hi, e_lo, tol2, tol2_neg;
    logic                      pos_hi, pos_lo, neg_hi, neg_lo;
    logic signed [SIG_W-1:0]   res_sig;
    logic                      res_valid;

    logic                      out_valid_reg, out_valid_next;
    logic signed [SIG_W-1:0]   out_sig_reg, out_sig_next;
    logic                      out_last_reg, out_last_next;
    logic                      skid_valid_reg, skid_valid_next;
    logic signed [SIG_W-1:0]   skid_sig_reg, skid_sig_next;
    logic                      skid_last_reg, skid_last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg        <= '0;
            count_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_TOLERANCE:  tol_reg        <= cfg_data[TOL_W-1:0];
                CFG_COUNT_MODE: count_mode_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    always_comb
    begin
        a11      = s_axis_tdata[0*DATA_W +: DATA_W];
        a21      = s_axis_tdata[1*DATA_W +: DATA_W];
        a12      = s_axis_tdata[2*DATA_W +: DATA_W];
        a22      = s_axis_tdata[3*DATA_W +: DATA_W];
        trace_in = TRACE_W'(a11) + TRACE_W'(a22);
        diff_in  = TRACE_W'(a11) - TRACE_W'(a22);
        abs_in   = diff_in[TRACE_W-1] ? ABS_W'(-diff_in) : ABS_W'(diff_in);
        prod_in  = PROD_W'(a12) * PROD_W'(a21);
    end

    always_comb
    begin
        disc_sum = $signed({2'b00, b_sq_reg})
                 + $signed({{2{b_prod_reg[PROD_W-1]}}, b_prod_reg, 2'b00});
        disc_next = disc_sum[SUM_W-1] ? '0 : disc_sum[DISC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s_axis_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg <= '{last: s_axis_tlast, trace: trace_in};
            a_abs_reg  <= abs_in;
            a_prod_reg <= prod_in;
            b_side_reg <= a_side_reg;
            b_sq_reg   <= a_abs_reg * a_abs_reg;
            b_prod_reg <= a_prod_reg;
            c_side_reg <= b_side_reg;
            c_disc_reg <= disc_next;
        end
    end

    m2s_sqrt u_sqrt
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (c_valid_reg),
        .in_radicand ({{(RAD_W - DISC_W){1'b0}}, c_disc_reg}),
        .in_side     (c_side_reg),
        .out_valid   (sq_valid),
        .out_root    (sq_root),
        .out_side    (sq_side)
    );

    always_comb
    begin
        e_hi     = EIG_W'(sq_side.trace) + $signed({2'b00, sq_root});
        e_lo     = EIG_W'(sq_side.trace) - $signed({2'b00, sq_root});
        tol2     = $signed({{(EIG_W - TOL_W - 1){1'b0}}, tol_reg, 1'b0});
        tol2_neg = -tol2;
        pos_hi   = (e_hi >= tol2);
        pos_lo   = (e_lo >= tol2);
        neg_hi   = (e_hi <= tol2_neg);
        neg_lo   = (e_lo <= tol2_neg);
        if (count_mode_reg)
        begin
            res_sig = SIG_W'(pos_hi) + SIG_W'(pos_lo);
        end
        else
        begin
            res_sig = SIG_W'(pos_hi) - SIG_W'(neg_hi) + SIG_W'(pos_lo) - SIG_W'(neg_lo);
        end
        res_valid = sq_valid && en;
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_sig_next    = out_sig_reg;
        out_last_next   = out_last_reg;
        skid_valid_next = skid_valid_reg;
        skid_sig_next   = skid_sig_reg;
        skid_last_next  = skid_last_reg;
        if (skid_valid_reg)
        begin
            if (m_axis_tready)
            begin
                out_sig_next    = skid_sig_reg;
                out_last_next   = skid_last_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (m_axis_tready || !out_valid_reg)
        begin
            out_valid_next = res_valid;
            out_sig_next   = res_sig;
            out_last_next  = sq_side.last;
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_sig_next   = res_sig;
            skid_last_next  = sq_side.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sig_reg   <= out_sig_next;
        out_last_reg  <= out_last_next;
        skid_sig_reg  <= skid_sig_next;
        skid_last_reg <= skid_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - SIG_W){1'b0}}, out_sig_reg};
    assign m_axis_tlast  = out_last_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !m_axis_tready |=>
            skid_valid_reg && $stable(skid_sig_reg) && $stable(skid_last_reg))
        else $error("skid item lost or altered during stall");

    a_sig_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_sig_reg != 3'sd3) && (out_sig_reg != -3'sd3)
            && (out_sig_reg != -3'sd4))
        else $error("signature outside -2..2");

endmodule

// ----- hdl/m2s_sqrt.sv -----
// ----------------------------------------------------------------------------
// m2s_sqrt
// Pipelined restoring floor square root: one root bit per stage, with a
// sideband that travels alongside each item.
// ----------------------------------------------------------------------------
module m2s_sqrt
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [m2s_pkg::RAD_W-1:0]   in_radicand,
    input  m2s_pkg::side_t              in_side,
    output logic                        out_valid,
    output logic [m2s_pkg::ROOT_W-1:0]  out_root,
    output m2s_pkg::side_t              out_side
);
    import m2s_pkg::*;

    logic [SQRT_STAGES-1:0] valid_reg;
    logic [RAD_W-1:0]       rad_reg  [SQRT_STAGES];
    logic [REM_W-1:0]       rem_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0]      root_reg [SQRT_STAGES];
    side_t                  side_reg [SQRT_STAGES];

    for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
        logic              valid_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        side_t             side_in;
        logic [STEP_W-1:0] rem_shift;
        logic [STEP_W-1:0] trial;
        logic              take;
        logic [STEP_W-1:0] rem_diff;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;
        logic [RAD_W-1:0]  rad_next;

        if (i == 0) begin : g_first
            assign valid_in = in_valid;
            assign rad_in   = in_radicand;
            assign rem_in   = '0;
            assign root_in  = '0;
            assign side_in  = in_side;
        end
        else begin : g_next
            assign valid_in = valid_reg[i-1];
            assign rad_in   = rad_reg[i-1];
            assign rem_in   = rem_reg[i-1];
            assign root_in  = root_reg[i-1];
            assign side_in  = side_reg[i-1];
        end

        always_comb
        begin
            rem_shift = {rem_in, rad_in[RAD_W-1 -: 2]};
            trial     = {2'b00, root_in, 2'b01};
            take      = (rem_shift >= trial);
            rem_diff  = rem_shift - trial;
            rem_next  = take ? rem_diff[REM_W-1:0] : rem_shift[REM_W-1:0];
            root_next = {root_in[ROOT_W-2:0], take};
            rad_next  = {rad_in[RAD_W-3:0], 2'b00};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[i]  <= rad_next;
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[SQRT_STAGES-1];
    assign out_root  = root_reg[SQRT_STAGES-1];
    assign out_side  = side_reg[SQRT_STAGES-1];

endmodule
